>>> hdl/pcpm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcpm_pkg
// Types and codes shared by the PWM capture period and pulse measurement block.
// ----------------------------------------------------------------------------
package pcpm_pkg;

  localparam logic [2:0] OP_CAP_A  = 3'd0;
  localparam logic [2:0] OP_CAP_B  = 3'd1;
  localparam logic [2:0] OP_OVF    = 3'd2;
  localparam logic [2:0] OP_CANCEL = 3'd3;
  localparam logic [2:0] OP_ARM    = 3'd4;
  localparam logic [2:0] OP_DISARM = 3'd5;

  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_MEASURE = 3'd1;
  localparam logic [2:0] ST_CANCEL  = 3'd2;
  localparam logic [2:0] ST_BUSY    = 3'd3;
  localparam logic [2:0] ST_ACCEPT  = 3'd4;

  localparam logic [1:0] MODE_PERIOD = 2'd0;
  localparam logic [1:0] MODE_PULSE  = 2'd1;
  localparam logic [1:0] MODE_BOTH   = 2'd2;

  localparam logic [2:0] REG_CAPTURE_MODE  = 3'd0;
  localparam logic [2:0] REG_CONTINUOUS    = 3'd1;
  localparam logic [2:0] REG_SHORT_COUNTER = 3'd2;
  localparam logic [2:0] REG_TIMER_PERIOD  = 3'd3;
  localparam logic [2:0] REG_CANCEL_PIN    = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] capture_value;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        pin;
    logic [63:0] period_value;
    logic [63:0] pulse_value;
    logic        auto_stopped;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]  capture_mode;
    logic        continuous;
    logic        short_counter;
    logic [31:0] timer_period;
    logic        cancel_pin;
  } cfg_t;

endpackage
`default_nettype wire

>>> hdl/pcpm_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcpm_cfg
// Configuration register file, written by index.
// ----------------------------------------------------------------------------
module pcpm_cfg
  import pcpm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_CAPTURE_MODE:  cfg_nxt.capture_mode  = cfg_data[1:0];
        REG_CONTINUOUS:    cfg_nxt.continuous    = cfg_data[0];
        REG_SHORT_COUNTER: cfg_nxt.short_counter = cfg_data[0];
        REG_TIMER_PERIOD:  cfg_nxt.timer_period  = cfg_data;
        REG_CANCEL_PIN:    cfg_nxt.cancel_pin    = cfg_data[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

>>> hdl/pcpm_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcpm_core
// Measurement state and per-beat evaluation: overflow extension, mode
// sequencing and arm control.
// ----------------------------------------------------------------------------
module pcpm_core
  import pcpm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     step,
  input  wire in_beat_t item,
  input  wire cfg_t     cfg,
  output out_beat_t     result
);

  logic        armed_r, armed_nxt;
  logic [31:0] ovf_cnt_r, ovf_cnt_nxt;
  logic        pulse_seen_r, pulse_seen_nxt;
  logic [63:0] held_pulse_r, held_pulse_nxt;

  logic [63:0] scaled;
  logic [63:0] value;

  always_comb begin
    if (cfg.timer_period != '0) begin
      scaled = 64'(ovf_cnt_r) * 64'(cfg.timer_period);
    end else if (cfg.short_counter) begin
      scaled = {16'd0, ovf_cnt_r, 16'd0};
    end else begin
      scaled = {ovf_cnt_r, 32'd0};
    end
    value = scaled + 64'(item.capture_value);
  end

  always_comb begin
    result         = '0;
    armed_nxt      = armed_r;
    ovf_cnt_nxt    = ovf_cnt_r;
    pulse_seen_nxt = pulse_seen_r;
    held_pulse_nxt = held_pulse_r;
    unique case (item.op)
      OP_ARM: begin
        if (armed_r) begin
          result.status = ST_BUSY;
        end else begin
          armed_nxt      = 1'b1;
          pulse_seen_nxt = 1'b0;
          result.status  = ST_ACCEPT;
        end
      end
      OP_DISARM: begin
        armed_nxt     = 1'b0;
        result.status = ST_ACCEPT;
      end
      OP_OVF: begin
        if (armed_r) begin
          ovf_cnt_nxt = ovf_cnt_r + 32'd1;
        end
      end
      OP_CANCEL: begin
        if (armed_r) begin
          result.status = ST_CANCEL;
          result.pin    = cfg.cancel_pin;
        end
      end
      OP_CAP_A, OP_CAP_B: begin
        if (armed_r && item.capture_value != '0) begin
          if (cfg.capture_mode == MODE_BOTH && !pulse_seen_r) begin
            held_pulse_nxt = value;
            pulse_seen_nxt = 1'b1;
          end else begin
            if (cfg.capture_mode == MODE_BOTH) begin
              pulse_seen_nxt      = 1'b0;
              result.period_value = value;
              result.pulse_value  = held_pulse_r;
            end else if (cfg.capture_mode == MODE_PULSE) begin
              result.pulse_value = value;
            end else begin
              result.period_value = value;
            end
            ovf_cnt_nxt         = '0;
            result.status       = ST_MEASURE;
            result.pin          = (item.op == OP_CAP_B);
            result.auto_stopped = !cfg.continuous;
            if (!cfg.continuous) begin
              armed_nxt = 1'b0;
            end
          end
        end
      end
      default: result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r      <= 1'b0;
      ovf_cnt_r    <= '0;
      pulse_seen_r <= 1'b0;
      held_pulse_r <= '0;
    end else if (step) begin
      armed_r      <= armed_nxt;
      ovf_cnt_r    <= ovf_cnt_nxt;
      pulse_seen_r <= pulse_seen_nxt;
      held_pulse_r <= held_pulse_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/pwm_capture_period_pulse_measure.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_capture_period_pulse_measure
// PWM input capture with overflow-extended period and pulse measurement.
// ----------------------------------------------------------------------------
// Usage:
//   Timer events arrive as beats on the in_ channel (valid/stall). Each beat
//   yields exactly one result beat on the out_ channel (valid/stall), in order.
//   Configuration registers are written through cfg_we/cfg_index/cfg_data
//   while the block is idle.
// Datapath and throughput:
//   A beat is held in an input register, evaluated against the measurement
//   state, and placed in the result register, which drives out_valid. One
//   beat per cycle is sustained while out_stall is low; the single 32x32
//   multiply-add between the two registers sets the cycle.
// Reset:
//   rst_n (synchronous) empties both registers, disarms, clears the overflow
//   count, the held pulse and all configuration registers.
// Stall:
//   While out_stall holds a result, the input register still takes one more
//   beat; in_stall rises only when both registers are full.
// ----------------------------------------------------------------------------
module pwm_capture_period_pulse_measure
  import pcpm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_beat_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_beat_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  cfg_t      cfg;
  in_beat_t  item_r;
  logic      item_valid_r;
  out_beat_t result;
  out_beat_t out_r;
  logic      out_valid_r;
  logic      advance;
  logic      step;

  assign advance  = !out_valid_r || !out_stall;
  assign step     = item_valid_r && advance;
  assign in_stall = item_valid_r && !advance;

  pcpm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pcpm_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (!in_stall) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> item_valid_r && out_valid_r)
    else $error("input stalled without a held beat");

  a_stop_only_on_measure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.auto_stopped |-> out_r.status == ST_MEASURE)
    else $error("auto stop flagged on a non-measurement result");

  a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("evaluated beat did not reach the result register");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !item_valid_r)
    else $error("registers not empty after reset");

endmodule
`default_nettype wire

>>> tb/pwm_capture_period_pulse_measure_tb.sv
// ----------------------------------------------------------------------------
// pwm_capture_period_pulse_measure_tb
// Self-checking bench for the PWM capture period and pulse measurement block.
// A directed table covers the disarmed, zero-capture, busy, cancel, both-mode
// and unused-code cases. Random timer event streams follow under several
// register settings and idle/stall mixes. Every result beat is compared field
// by field against the table or an in-bench model of the measurement state.
// ----------------------------------------------------------------------------
module pwm_capture_period_pulse_measure_tb
  import pcpm_pkg::*;
();

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [2:0] OP_RSVD6    = 3'd6;
  localparam logic [2:0] OP_RSVD7    = 3'd7;
  localparam logic       ROW_ITEM    = 1'b0;
  localparam logic       ROW_REG     = 1'b1;
  localparam int         N_PHASES    = 8;
  localparam int         PHASE_BEATS = 130;
  localparam int         CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic        kind;
    logic [2:0]  code;
    logic [31:0] val;
    logic        typed;
    out_beat_t   exp;
  } row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_beat_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      cfg_we    = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;
  logic      in_stall;
  logic      out_valid;
  out_beat_t out_data;

  cfg_t        cur_cfg        = '0;
  logic        armed_q        = 1'b0;
  logic [31:0] ovf_count      = '0;
  logic        pulse_pending  = 1'b0;
  logic [63:0] held_pulse_val = '0;

  out_beat_t pending_results[$];
  row_t      dir_rows[$];
  int idle_pct   = 0;
  int stall_pct  = 0;
  int errors     = 0;
  int n_sent     = 0;
  int n_checked  = 0;
  int n_meas     = 0;
  int n_settings = 0;
  int cycles     = 0;

  pwm_capture_period_pulse_measure DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic out_beat_t step_capture(input in_beat_t b);
    out_beat_t   r;
    logic [63:0] span;
    logic [63:0] meas;
    r = '0;
    if (cur_cfg.timer_period != 32'd0) begin
      span = {32'd0, cur_cfg.timer_period};
    end else begin
      span = cur_cfg.short_counter ? 64'h0000_0000_0001_0000 : 64'h0000_0001_0000_0000;
    end
    meas = {32'd0, ovf_count} * span + {32'd0, b.capture_value};
    case (b.op)
      OP_ARM: begin
        if (armed_q) begin
          r.status = ST_BUSY;
        end else begin
          armed_q       = 1'b1;
          pulse_pending = 1'b0;
          r.status      = ST_ACCEPT;
        end
      end
      OP_DISARM: begin
        armed_q  = 1'b0;
        r.status = ST_ACCEPT;
      end
      OP_OVF: begin
        if (armed_q) ovf_count = ovf_count + 32'd1;
      end
      OP_CANCEL: begin
        if (armed_q) begin
          r.status = ST_CANCEL;
          r.pin    = cur_cfg.cancel_pin;
        end
      end
      OP_CAP_A, OP_CAP_B: begin
        if (armed_q && b.capture_value != 32'd0) begin
          if (cur_cfg.capture_mode == MODE_BOTH && !pulse_pending) begin
            held_pulse_val = meas;
            pulse_pending  = 1'b1;
          end else begin
            r.status = ST_MEASURE;
            r.pin    = b.op[0];
            if (cur_cfg.capture_mode == MODE_BOTH) begin
              pulse_pending  = 1'b0;
              r.period_value = meas;
              r.pulse_value  = held_pulse_val;
            end else if (cur_cfg.capture_mode == MODE_PULSE) begin
              r.pulse_value = meas;
            end else begin
              r.period_value = meas;
            end
            ovf_count      = '0;
            r.auto_stopped = ~cur_cfg.continuous;
            if (!cur_cfg.continuous) armed_q = 1'b0;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pick_capture();
    case ($urandom_range(3))
      0: return 32'd1;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1000, 1);
      default: return ($urandom | 32'd1) ^ ($urandom_range(1) ? 32'd0 : 32'd1) | 32'h8000_0000;
    endcase
  endfunction

  function automatic in_beat_t gen_event();
    in_beat_t b;
    int       r;
    b.op          = 3'($urandom_range(7));
    b.capture_value = $urandom;
    r = $urandom_range(99);
    if (!armed_q) begin
      if (r < 70) b.op = OP_ARM;
    end else if (r < 45) begin
      b.op            = $urandom_range(1) ? OP_CAP_B : OP_CAP_A;
      b.capture_value = pick_capture();
    end else if (r < 75) begin
      b.op = OP_OVF;
    end else if (r < 80) begin
      b.op = OP_ARM;
    end else if (r < 84) begin
      b.op = OP_DISARM;
    end else if (r < 88) begin
      b.op = OP_CANCEL;
    end else if (r < 92) begin
      b.op            = $urandom_range(1) ? OP_CAP_B : OP_CAP_A;
      b.capture_value = '0;
    end
    return b;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH at cycle %0d: %s got %h want %h", cycles, what, got, want);
    errors++;
  endtask

  task automatic check_beat(input out_beat_t got);
    out_beat_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result beat, status", 64'(got.status), '0);
    end else begin
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", 64'(got.status), 64'(want.status));
      if (got.pin !== want.pin) report_mismatch("pin", 64'(got.pin), 64'(want.pin));
      if (got.period_value !== want.period_value)
        report_mismatch("period_value", got.period_value, want.period_value);
      if (got.pulse_value !== want.pulse_value)
        report_mismatch("pulse_value", got.pulse_value, want.pulse_value);
      if (got.auto_stopped !== want.auto_stopped)
        report_mismatch("auto_stopped", 64'(got.auto_stopped), 64'(want.auto_stopped));
      if (want.status == ST_MEASURE) n_meas++;
      n_checked++;
    end
  endtask

  always @(posedge clk) begin
    if (out_valid && !out_stall) check_beat(out_data);
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    drain();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CAPTURE_MODE:  cur_cfg.capture_mode  = v[1:0];
      REG_CONTINUOUS:    cur_cfg.continuous    = v[0];
      REG_SHORT_COUNTER: cur_cfg.short_counter = v[0];
      REG_TIMER_PERIOD:  cur_cfg.timer_period  = v;
      REG_CANCEL_PIN:    cur_cfg.cancel_pin    = v[0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input cfg_t c);
    write_reg(REG_CAPTURE_MODE, {30'd0, c.capture_mode});
    write_reg(REG_CONTINUOUS, {31'd0, c.continuous});
    write_reg(REG_SHORT_COUNTER, {31'd0, c.short_counter});
    write_reg(REG_TIMER_PERIOD, c.timer_period);
    write_reg(REG_CANCEL_PIN, {31'd0, c.cancel_pin});
    n_settings++;
  endtask

  task automatic send_beat(input in_beat_t b, input logic typed, input out_beat_t want);
    out_beat_t pred;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    pred = step_capture(b);
    pending_results.push_back(typed ? want : pred);
    n_sent++;
  endtask

  task automatic dir_item(input logic [2:0] op, input logic [31:0] v);
    row_t r;
    r      = '0;
    r.kind = ROW_ITEM;
    r.code = op;
    r.val  = v;
    dir_rows.push_back(r);
  endtask

  task automatic dir_known(input logic [2:0] op, input logic [31:0] v,
                           input logic [2:0] st, input logic pin,
                           input logic [63:0] per, input logic [63:0] pul,
                           input logic stop);
    row_t r;
    r                  = '0;
    r.kind             = ROW_ITEM;
    r.code             = op;
    r.val              = v;
    r.typed            = 1'b1;
    r.exp.status       = st;
    r.exp.pin          = pin;
    r.exp.period_value = per;
    r.exp.pulse_value  = pul;
    r.exp.auto_stopped = stop;
    dir_rows.push_back(r);
  endtask

  task automatic dir_reg(input logic [2:0] idx, input logic [31:0] v);
    row_t r;
    r      = '0;
    r.kind = ROW_REG;
    r.code = idx;
    r.val  = v;
    dir_rows.push_back(r);
  endtask

  initial begin
    in_beat_t b;
    cfg_t     c;
    row_t     r;
    int       p;
    int       k;

    dir_known(OP_CAP_A,   32'd5,        ST_NONE,    1'b0, 64'd0, 64'd0, 1'b0);
    dir_known(OP_OVF,     32'd0,        ST_NONE,    1'b0, 64'd0, 64'd0, 1'b0);
    dir_known(OP_CANCEL,  32'd0,        ST_NONE,    1'b0, 64'd0, 64'd0, 1'b0);
    dir_known(OP_RSVD6,   32'hFFFF_FFFF, ST_NONE,   1'b0, 64'd0, 64'd0, 1'b0);
    dir_known(OP_RSVD7,   32'd1,        ST_NONE,    1'b0, 64'd0, 64'd0, 1'b0);
    dir_known(OP_DISARM,  32'd0,        ST_ACCEPT,  1'b0, 64'd0, 64'd0, 1'b0);
    dir_known(OP_ARM,     32'd0,        ST_ACCEPT,  1'b0, 64'd0, 64'd0, 1'b0);
    dir_known(OP_ARM,     32'd0,        ST_BUSY,    1'b0, 64'd0, 64'd0, 1'b0);
    dir_known(OP_CAP_A,   32'd0,        ST_NONE,    1'b0, 64'd0, 64'd0, 1'b0);
    dir_known(OP_OVF,     32'd0,        ST_NONE,    1'b0, 64'd0, 64'd0, 1'b0);
    dir_known(OP_CANCEL,  32'd0,        ST_CANCEL,  1'b0, 64'd0, 64'd0, 1'b0);
    dir_known(OP_CAP_B,   32'hFFFF_FFFF, ST_MEASURE, 1'b1,
              64'h0000_0001_FFFF_FFFF, 64'd0, 1'b1);
    dir_known(OP_CAP_A,   32'd9,        ST_NONE,    1'b0, 64'd0, 64'd0, 1'b0);
    dir_reg(REG_CAPTURE_MODE, {30'd0, MODE_BOTH});
    dir_reg(REG_CONTINUOUS, 32'd1);
    dir_reg(REG_SHORT_COUNTER, 32'd1);
    dir_reg(REG_CANCEL_PIN, 32'd1);
    dir_known(OP_ARM,     32'd0,        ST_ACCEPT,  1'b0, 64'd0, 64'd0, 1'b0);
    dir_item(OP_OVF, 32'd0);
    dir_known(OP_CAP_A,   32'd1,        ST_NONE,    1'b0, 64'd0, 64'd0, 1'b0);
    dir_item(OP_CAP_B, 32'd2);
    dir_known(OP_CANCEL,  32'd0,        ST_CANCEL,  1'b1, 64'd0, 64'd0, 1'b0);
    dir_reg(REG_CAPTURE_MODE, {30'd0, MODE_UNUSED});
    dir_reg(REG_TIMER_PERIOD, 32'hFFFF_FFFF);
    dir_item(OP_OVF, 32'd0);
    dir_item(OP_CAP_A, 32'hFFFF_FFFF);
    dir_reg(REG_CAPTURE_MODE, {30'd0, MODE_PULSE});
    dir_item(OP_CAP_B, 32'd7);
    dir_known(OP_DISARM,  32'd0,        ST_ACCEPT,  1'b0, 64'd0, 64'd0, 1'b0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.kind == ROW_REG) begin
        write_reg(r.code, r.val);
      end else begin
        b.op            = r.code;
        b.capture_value = r.val;
        send_beat(b, r.typed, r.exp);
      end
    end

    for (p = 0; p < N_PHASES; p++) begin
      case (p)
        0: c = '{MODE_PERIOD, 1'b0, 1'b0, 32'd0, 1'b0};
        1: c = '{MODE_PULSE, 1'b1, 1'b1, 32'd0, 1'b1};
        2: c = '{MODE_BOTH, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0};
        3: c = '{MODE_UNUSED, 1'b0, 1'b1, 32'd1, 1'b1};
        default: begin
          c.capture_mode  = 2'($urandom_range(3));
          c.continuous    = 1'($urandom_range(1));
          c.short_counter = 1'($urandom_range(1));
          c.cancel_pin    = 1'($urandom_range(1));
          case ($urandom_range(3))
            0: c.timer_period = 32'd0;
            1: c.timer_period = $urandom_range(70000, 1);
            2: c.timer_period = $urandom;
            default: c.timer_period = 32'hFFFF_FFFF;
          endcase
        end
      endcase
      program_regs(c);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 82; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 82; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      for (k = 0; k < PHASE_BEATS; k++) begin
        if (k == PHASE_BEATS / 2) drain();
        send_beat(gen_event(), 1'b0, '0);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d event beats over %0d register settings and 4 idle/stall mixes.",
             n_sent, n_settings);
    $display("Checked %0d result beats, %0d of them measurements; %0d mismatches.",
             n_checked, n_meas, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/pcpm_pkg.sv
hdl/pcpm_cfg.sv
hdl/pcpm_core.sv
hdl/pwm_capture_period_pulse_measure.sv
tb/pwm_capture_period_pulse_measure_tb.sv
